// File: rtl/appbe_pkg.sv
// ----------------------------------------------------------------------------
// appbe_pkg
// Types and constants shared by the push/pop/branch emulator modules.
// ----------------------------------------------------------------------------
package appbe_pkg;

    // Item codes carried on s_tuser
    typedef enum logic [2:0] {
        ACT_WR_REG = 3'd0,
        ACT_RD_REG = 3'd1,
        ACT_WR_MEM = 3'd2,
        ACT_RD_MEM = 3'd3,
        ACT_PUSH   = 3'd4,
        ACT_POP    = 3'd5,
        ACT_BRANCH = 3'd6,
        ACT_UNDEF  = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_REDUCE,
        ST_EXEC,
        ST_PUSH,
        ST_POP,
        ST_FINISH,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic ptr_init;
        logic ptr_step;
        logic exec;
        logic step;
        logic finish;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        action_t action;
        logic    reduce_req;
        logic    reduce_last;
        logic    step_last;
    } sts_t;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_LR = 4'd14;
    localparam logic [3:0] REG_PC = 4'd15;

    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned M_TDATA_W = 96;

    // Steps of the word address reduction modulo the memory depth:
    // quotient estimate, remainder, final correction
    localparam int unsigned REDUCE_STEPS = 3;

endpackage

// File: rtl/appbe_ctrl.sv
// ----------------------------------------------------------------------------
// appbe_ctrl
// Sequencer: accepts one item, steps the datapath through it and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module appbe_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  appbe_pkg::sts_t    sts,
    output appbe_pkg::cmd_t    cmd
);

    appbe_pkg::state_t state_reg, state_next;
    appbe_pkg::state_t dispatch;
    logic              m_tvalid_reg, m_tvalid_next;

    always_comb begin
        case (sts.action)
            appbe_pkg::ACT_PUSH: dispatch = appbe_pkg::ST_PUSH;
            appbe_pkg::ACT_POP:  dispatch = appbe_pkg::ST_POP;
            default:             dispatch = appbe_pkg::ST_EXEC;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            appbe_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = appbe_pkg::ST_START;
            end
            appbe_pkg::ST_START: begin
                state_next = sts.reduce_req ? appbe_pkg::ST_REDUCE : dispatch;
            end
            appbe_pkg::ST_REDUCE: begin
                if (sts.reduce_last) state_next = dispatch;
            end
            appbe_pkg::ST_EXEC: begin
                state_next = appbe_pkg::ST_DONE;
            end
            appbe_pkg::ST_PUSH, appbe_pkg::ST_POP: begin
                if (sts.step_last) state_next = appbe_pkg::ST_FINISH;
            end
            appbe_pkg::ST_FINISH: begin
                state_next = appbe_pkg::ST_DONE;
            end
            appbe_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = appbe_pkg::ST_IDLE;
            end
            default: begin
                state_next = appbe_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            appbe_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            appbe_pkg::ST_START:  cmd.ptr_init = 1'b1;
            appbe_pkg::ST_REDUCE: cmd.ptr_step = 1'b1;
            appbe_pkg::ST_EXEC:   cmd.exec     = 1'b1;
            appbe_pkg::ST_PUSH, appbe_pkg::ST_POP: cmd.step = 1'b1;
            appbe_pkg::ST_FINISH: cmd.finish   = 1'b1;
            appbe_pkg::ST_DONE:   cmd.out_load = !m_tvalid_reg || m_tready;
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= appbe_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// File: rtl/appbe_dp.sv
// ----------------------------------------------------------------------------
// appbe_dp
// Register file, stack memory, stack address walker and result register.
// ----------------------------------------------------------------------------
module appbe_dp #(
    parameter int unsigned STACK_WORDS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  appbe_pkg::cmd_t     cmd,
    output appbe_pkg::sts_t     sts,
    input  logic [2:0]          in_action,
    input  logic [3:0]          in_reg_index,
    input  logic [9:0]          in_word_index,
    input  logic [31:0]         in_data_value,
    input  logic [15:0]         in_reg_list,
    input  logic [23:0]         in_branch_offset,
    output logic [31:0]         out_read_data,
    output logic [31:0]         out_pc_value,
    output logic [31:0]         out_sp_value,
    output logic                out_status
);

    localparam int unsigned AW = $clog2(STACK_WORDS);
    localparam bit          POW2 = (STACK_WORDS & (STACK_WORDS - 1)) == 0;
    localparam logic [29:0]   DEPTH    = 30'(STACK_WORDS);
    // floor(2^30 / depth): the quotient estimate is at most one short
    localparam logic [29:0]   RECIP    = 30'((32'd1 << 30) / STACK_WORDS);
    localparam logic [AW-1:0] LAST_W   = AW'(STACK_WORDS - 1);
    // word reached when the 30-bit word address wraps below zero
    localparam logic [AW-1:0] WRAP_LO  = AW'(32'h3fff_ffff % STACK_WORDS);
    localparam logic [4:0]    RED_LAST = 5'(appbe_pkg::REDUCE_STEPS - 1);

    // Item registers
    appbe_pkg::action_t act_reg;
    logic [3:0]         ridx_reg;
    logic [9:0]         widx_reg;
    logic [31:0]        dval_reg;
    logic [15:0]        list_reg;
    logic [23:0]        offs_reg;

    logic [31:0]   rf_reg [16];
    logic [31:0]   mem [STACK_WORDS];
    logic [31:0]   mem_rd_reg;

    logic [31:0]   addr_reg;
    logic [AW-1:0] wptr_reg;
    logic [29:0]   src_reg;
    logic [29:0]   red_reg;
    logic [4:0]    cnt_reg;
    logic          pend_valid_reg;
    logic [3:0]    pend_idx_reg;
    logic [31:0]   new_sp_reg;

    logic          is_push, is_pop;
    logic [3:0]    idx;
    logic          lbit;
    logic [3:0]    rf_raddr;
    logic [31:0]   rf_rdata;
    logic [29:0]   ptr_src;
    logic [59:0]   red_prod;
    logic [29:0]   red_fix;
    logic [AW-1:0] wptr_dec, wptr_inc;
    logic [31:0]   br_delta;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;
    logic [31:0]   rd_sel;

    assign is_push  = act_reg == appbe_pkg::ACT_PUSH;
    assign is_pop   = act_reg == appbe_pkg::ACT_POP;
    // push walks pc down to r0, pop walks r0 up to pc
    assign idx      = is_push ? ~cnt_reg[3:0] : cnt_reg[3:0];
    assign lbit     = list_reg[idx];
    assign rf_raddr = cmd.step ? idx : ridx_reg;
    assign rf_rdata = rf_reg[rf_raddr];

    assign ptr_src = (is_push || is_pop) ? rf_reg[appbe_pkg::REG_SP][31:2]
                                         : 30'(widx_reg);

    // reduction by the memory depth: reciprocal quotient, then one correction
    assign red_prod = 60'(src_reg) * 60'(RECIP);
    assign red_fix  = (red_reg >= DEPTH) ? red_reg - DEPTH : red_reg;

    assign wptr_dec = (addr_reg[31:2] == '0) ? WRAP_LO :
                      (wptr_reg == '0) ? LAST_W : wptr_reg - AW'(1);
    assign wptr_inc = (addr_reg[31:2] == '1) ? '0 :
                      (wptr_reg == LAST_W) ? '0 : wptr_reg + AW'(1);

    assign br_delta = {{6{offs_reg[23]}}, offs_reg, 2'b00} + 32'd8;

    assign sts.action      = act_reg;
    assign sts.reduce_req  = !POW2 && (act_reg == appbe_pkg::ACT_WR_MEM ||
                             act_reg == appbe_pkg::ACT_RD_MEM || is_push || is_pop);
    assign sts.reduce_last = cnt_reg == RED_LAST;
    assign sts.step_last   = cnt_reg[3:0] == 4'hf;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= appbe_pkg::action_t'(in_action);
            ridx_reg <= in_reg_index;
            widx_reg <= in_word_index;
            dval_reg <= in_data_value;
            list_reg <= in_reg_list;
            offs_reg <= in_branch_offset;
        end
    end

    // Stack address walker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.ptr_init) begin
            cnt_reg <= '0;
        end else if (cmd.ptr_step) begin
            cnt_reg <= sts.reduce_last ? 5'd0 : cnt_reg + 5'd1;
        end else if (cmd.step) begin
            cnt_reg <= sts.step_last ? 5'd0 : cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ptr_init) begin
            addr_reg <= rf_reg[appbe_pkg::REG_SP];
            src_reg  <= ptr_src;
            wptr_reg <= POW2 ? ptr_src[AW-1:0] : '0;
        end else if (cmd.ptr_step) begin
            case (cnt_reg[1:0])
                2'd0:    red_reg  <= red_prod[59:30];
                2'd1:    red_reg  <= src_reg - red_reg * DEPTH;
                default: wptr_reg <= red_fix[AW-1:0];
            endcase
        end else if (cmd.step && lbit) begin
            if (is_push) begin
                addr_reg <= addr_reg - 32'd4;
                wptr_reg <= wptr_dec;
            end else begin
                addr_reg <= addr_reg + 32'd4;
                wptr_reg <= wptr_inc;
            end
        end
    end

    // Stack memory, one write and one registered read
    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = wptr_reg;
        mem_wd = dval_reg;
        if (cmd.exec && act_reg == appbe_pkg::ACT_WR_MEM) begin
            mem_we = 1'b1;
        end
        if (cmd.exec && act_reg == appbe_pkg::ACT_RD_MEM) begin
            mem_re = 1'b1;
        end
        if (cmd.step && lbit) begin
            mem_we = is_push;
            mem_re = is_pop;
            mem_wa = wptr_dec;
            mem_wd = rf_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_rd_reg <= mem[wptr_reg];
        end
    end

    // Pop data is written back from the registered read, tracked by these registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= cmd.step && is_pop && lbit;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= idx;
        if (pend_valid_reg && pend_idx_reg == appbe_pkg::REG_SP) begin
            new_sp_reg <= mem_rd_reg;
        end
    end

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_reg <= '{default: '0};
        end else begin
            if (cmd.exec && act_reg == appbe_pkg::ACT_WR_REG) begin
                rf_reg[ridx_reg] <= dval_reg;
            end
            if (cmd.exec && act_reg == appbe_pkg::ACT_BRANCH) begin
                rf_reg[appbe_pkg::REG_PC] <= rf_reg[appbe_pkg::REG_PC] + br_delta;
            end
            if (cmd.finish && is_push) begin
                rf_reg[appbe_pkg::REG_SP] <= addr_reg;
                rf_reg[appbe_pkg::REG_PC] <= rf_reg[appbe_pkg::REG_PC] + 32'd4;
            end
            if (cmd.finish && is_pop) begin
                rf_reg[appbe_pkg::REG_SP] <= list_reg[appbe_pkg::REG_SP] ? new_sp_reg
                                                                         : addr_reg;
                if (!list_reg[appbe_pkg::REG_PC]) begin
                    rf_reg[appbe_pkg::REG_PC] <= rf_reg[appbe_pkg::REG_PC] + 32'd4;
                end
            end
            if (pend_valid_reg && pend_idx_reg != appbe_pkg::REG_SP) begin
                rf_reg[pend_idx_reg] <= mem_rd_reg;
            end
        end
    end

    // Result register
    always_comb begin
        case (act_reg)
            appbe_pkg::ACT_RD_REG: rd_sel = rf_rdata;
            appbe_pkg::ACT_RD_MEM: rd_sel = mem_rd_reg;
            default:               rd_sel = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_read_data <= rd_sel;
            out_pc_value  <= rf_reg[appbe_pkg::REG_PC];
            out_sp_value  <= rf_reg[appbe_pkg::REG_SP];
            out_status    <= act_reg == appbe_pkg::ACT_UNDEF;
        end
    end

endmodule

// File: rtl/arm_push_pop_branch_emulator.sv
// ----------------------------------------------------------------------------
// arm_push_pop_branch_emulator
// Push-multiple, pop-multiple and branch on a 16-entry register file and a
// word stack memory, with register and memory access items.
// ----------------------------------------------------------------------------
// One item is in work at a time. Register access, memory access, branch and
// unrecognised items pass through start, execute and done before the next
// acceptance. Push and pop step through all 16 register slots on the stack
// memory, whether or not each is in the list, then finish. When STACK_WORDS
// is not a power of two, memory, push and pop items first reduce the word
// address modulo the memory depth through a reciprocal multiplication and
// one correction. A finished result sits in the output register, so the
// block takes the next item while m_tready is low; that result then waits.
module arm_push_pop_branch_emulator #(
    parameter int unsigned STACK_WORDS = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // reg_index[3:0], word_index[13:4], data_value[45:14], reg_list[61:46],
    // branch_offset[85:62], zero pad [87:86]
    input  logic [appbe_pkg::S_TDATA_W-1:0]  s_tdata,
    // action[2:0]
    input  logic [2:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data[31:0], pc_value[63:32], sp_value[95:64]
    output logic [appbe_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[0]
    output logic                             m_tuser
);

    appbe_pkg::cmd_t cmd;
    appbe_pkg::sts_t sts;
    logic [31:0]     rd_value, pc_value, sp_value;

    appbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    appbe_dp #(
        .STACK_WORDS (STACK_WORDS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .in_action        (s_tuser),
        .in_reg_index     (s_tdata[3:0]),
        .in_word_index    (s_tdata[13:4]),
        .in_data_value    (s_tdata[45:14]),
        .in_reg_list      (s_tdata[61:46]),
        .in_branch_offset (s_tdata[85:62]),
        .out_read_data    (rd_value),
        .out_pc_value     (pc_value),
        .out_sp_value     (sp_value),
        .out_status       (m_tuser)
    );

    assign m_tdata = {sp_value, pc_value, rd_value};

endmodule
